// ===== hdl/sbmd_pkg.sv =====
// Shared types and constants for the SSD block-match disparity engine.
`default_nettype none
package sbmd_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_IMG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_MAX_DISP    = 2'd2;
    localparam logic [1:0] REG_HALF_WINDOW = 2'd3;

    localparam int CFG_W   = 11;   // widest configuration register
    localparam int DISP_W  = 8;    // disparity counter, covers up to 256 candidates
    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int COST_W  = 24;
    localparam int OUT_W   = 56;   // 51 payload bits padded to whole bytes

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } sbmd_state_t;

    // Tag that travels with each line store read
    typedef struct packed {
        logic              valid;
        logic              first;    // first pixel of a window
        logic              last;     // last pixel of a window
        logic              final_w;  // last pixel of the last disparity
        logic              zero_r;   // right column falls left of the image
        logic [DISP_W-1:0] disp;
    } sbmd_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/sbmd_line_store.sv =====
// Left and right line stores: one write port and one registered read port each.
`default_nettype none
module sbmd_line_store
    import sbmd_pkg::*;
#(
    parameter int DEPTH = 15360,
    parameter int AW    = 14
)(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [PIX_W-1:0] wleft,
    input  wire logic [PIX_W-1:0] wright,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr_left,
    input  wire logic [AW-1:0]    raddr_right,
    output logic      [PIX_W-1:0] rleft,
    output logic      [PIX_W-1:0] rright
);

    logic [PIX_W-1:0] left_mem  [DEPTH];
    logic [PIX_W-1:0] right_mem [DEPTH];

    // left image rows
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            left_mem[waddr] <= wleft;
        end
        if (re)
        begin
            rleft <= left_mem[raddr_left];
        end
    end

    // right image rows
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            right_mem[waddr] <= wright;
        end
        if (re)
        begin
            rright <= right_mem[raddr_right];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sbmd_ssd_engine.sv =====
// Square, accumulate and running minimum over the pixel reads of one centre.
`default_nettype none
module sbmd_ssd_engine
    import sbmd_pkg::*;
#(
    parameter int SUM_W = 24
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  sbmd_ctrl_t             ctrl,
    input  wire logic [PIX_W-1:0]  left_px,
    input  wire logic [PIX_W-1:0]  right_px,
    output logic                   done,
    output logic      [DISP_W-1:0] best_disp,
    output logic      [SUM_W-1:0]  best_cost
);

    sbmd_ctrl_t        ctrl_s1_reg, ctrl_s2_reg;
    logic [15:0]       sq_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [SUM_W-1:0]  acc_next;
    logic [SUM_W-1:0]  best_reg;
    logic [DISP_W-1:0] best_d_reg;
    logic              done_reg;
    logic [8:0]        diff;
    logic [7:0]        mag;

    // tags line up with the registered memory data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_s1_reg <= '0;
            ctrl_s2_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            ctrl_s1_reg <= ctrl;
            ctrl_s2_reg <= ctrl_s1_reg;
            done_reg    <= ctrl_s2_reg.valid && ctrl_s2_reg.final_w;
        end
    end

    // absolute difference
    always_comb
    begin
        diff = {1'b0, left_px} - (ctrl_s1_reg.zero_r ? 9'd0 : {1'b0, right_px});
        mag  = diff[8] ? 8'(-diff) : diff[7:0];
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= 16'(mag * mag);
    end

    // window sum
    assign acc_next = (ctrl_s2_reg.first ? '0 : acc_reg) + SUM_W'(sq_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl_s2_reg.valid)
        begin
            acc_reg <= acc_next;
            // lowest disparity wins a tie
            if (ctrl_s2_reg.last && (ctrl_s2_reg.disp == '0 || acc_next < best_reg))
            begin
                best_reg   <= acc_next;
                best_d_reg <= ctrl_s2_reg.disp;
            end
        end
    end

    assign done      = done_reg;
    assign best_disp = best_d_reg;
    assign best_cost = best_reg;

endmodule
`default_nettype wire

// ===== hdl/ssd_block_match_disparity.sv =====
// Top level: pixel intake, line store addressing and the window/disparity sequencer.
//
// Left/right pixel pairs come in raster order and are written to line stores
// of 2*h+1 rows. A pixel that completes an interior window starts a search
// that reads the window one pixel pair per cycle for every disparity, so
// such a pixel occupies the block until the search ends; the single read
// port of each line store sets that pace. Pixels that complete no window
// are taken without a search. After a write of half_window the row slot is
// recomputed by repeated subtraction, with no pixel taken. Results leave
// through an output register, so the next pixel is taken while a result waits.
`default_nettype none
module ssd_block_match_disparity
    import sbmd_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HALF  = 7,
    parameter int MAX_DISP  = 128
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [15:0]      s_tdata,   // left_pixel[7:0], right_pixel[15:8]
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [OUT_W-1:0] m_tdata,   // disparity[6:0], center_x[16:7],
                                             // center_y[26:17], best_cost[50:27], zero
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_addr,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int NSLOT = 2 * MAX_HALF + 1;
    localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int HW    = $clog2(NSLOT + 1);
    localparam int HB    = $clog2(MAX_HALF + 1);
    localparam int DW    = $clog2(MAX_DISP + 1);
    localparam int DEPTH = NSLOT * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUM_W = $clog2(NSLOT * NSLOT * 65025 + 1);
    localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int RST_D = (128 > MAX_DISP) ? MAX_DISP : 128;
    localparam int RST_H = (5 > MAX_HALF) ? MAX_HALF : 5;

    sbmd_state_t state_reg, state_next;

    logic [WW-1:0]      width_reg;
    logic [10:0]        height_reg;
    logic [DW-1:0]      disp_reg;
    logic [HB-1:0]      half_reg;

    logic [XW-1:0]      x_reg;
    logic [9:0]         y_reg;
    logic [SW-1:0]      slot_reg;
    logic [9:0]         tmp_reg;

    logic [XW-1:0]      job_x_reg;
    logic [9:0]         job_y_reg;
    logic [SW-1:0]      start_slot_reg;
    logic [HW-1:0]      cnt_i_reg, cnt_j_reg;
    logic [DISP_W-1:0]  cnt_d_reg;
    logic [SW-1:0]      row_slot_reg;

    logic [HW-1:0]      span, slots;
    logic               accept, emit, load_out, end_i, end_j, end_d;
    logic [XW-1:0]      col, rcol;
    logic [SW-1:0]      slot_inc, row_inc;
    logic [9:0]         y_inc;
    logic [AW-1:0]      waddr, raddr_l, raddr_r;
    sbmd_ctrl_t         ctrl;
    logic [PIX_W-1:0]   rd_left, rd_right;
    logic               eng_done;
    logic [DISP_W-1:0]  best_disp;
    logic [SUM_W-1:0]   best_cost;
    logic               m_valid_reg;
    logic [OUT_W-1:0]   m_data_reg;
    logic [XW-1:0]      cx_full;
    logic [9:0]         cy_full;

    assign span  = HW'({half_reg, 1'b0});
    assign slots = span + HW'(1);

    assign accept = s_tvalid && s_tready;
    assign emit   = (x_reg >= span) && (y_reg >= span);

    assign slot_inc = (HW'(slot_reg) + HW'(1) == slots) ? '0 : SW'(slot_reg + SW'(1));
    assign row_inc  = (HW'(row_slot_reg) + HW'(1) == slots) ? '0 : SW'(row_slot_reg + SW'(1));
    assign y_inc    = (11'(y_reg) + 11'd1 >= height_reg) ? 10'd0 : 10'(y_reg + 10'd1);

    // window walk
    assign end_i = (cnt_i_reg == span);
    assign end_j = (cnt_j_reg == span);
    assign end_d = (DW'(cnt_d_reg) + DW'(1) == disp_reg);
    assign col   = XW'(job_x_reg - XW'(span) + XW'(cnt_i_reg));
    assign rcol  = XW'(col - XW'(cnt_d_reg));

    assign waddr   = AW'(AW'(slot_reg) * AW'(MAX_WIDTH) + AW'(x_reg));
    assign raddr_l = AW'(AW'(row_slot_reg) * AW'(MAX_WIDTH) + AW'(col));
    assign raddr_r = AW'(AW'(row_slot_reg) * AW'(MAX_WIDTH) + AW'(rcol));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we && cfg_addr == REG_HALF_WINDOW)
                    state_next = ST_MOD;
                else if (accept && emit)
                    state_next = ST_RUN;
            end
            ST_MOD:
            begin
                if (cfg_we && cfg_addr == REG_HALF_WINDOW)
                    state_next = ST_MOD;
                else if (tmp_reg < 10'(slots))
                    state_next = ST_IDLE;
            end
            ST_RUN:
            begin
                if (end_i && end_j && end_d)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (eng_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_OUT:   load_out = !m_valid_reg || m_tready;
            ST_MOD, ST_RUN, ST_DRAIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers, saturated on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(RST_W);
            height_reg <= 11'd480;
            disp_reg   <= DW'(RST_D);
            half_reg   <= HB'(RST_H);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_IMG_WIDTH:
                    width_reg <= (cfg_data == '0) ? WW'(1) :
                                 (32'(cfg_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data);
                REG_IMG_HEIGHT:
                    height_reg <= (cfg_data == '0) ? 11'd1 :
                                  (cfg_data > 11'd1024) ? 11'd1024 : cfg_data;
                REG_MAX_DISP:
                    disp_reg <= (cfg_data[7:0] == '0) ? DW'(1) :
                                (32'(cfg_data[7:0]) > MAX_DISP) ? DW'(MAX_DISP) :
                                DW'(cfg_data[7:0]);
                REG_HALF_WINDOW:
                    half_reg <= (32'(cfg_data[2:0]) > MAX_HALF) ? HB'(MAX_HALF) :
                                HB'(cfg_data[2:0]);
                default: ;
            endcase
        end
    end

    // raster position and row slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            slot_reg <= '0;
            tmp_reg  <= '0;
        end
        else if (state_reg == ST_IDLE && cfg_we && cfg_addr == REG_HALF_WINDOW)
        begin
            tmp_reg <= y_reg;
        end
        else if (state_reg == ST_MOD)
        begin
            if (cfg_we && cfg_addr == REG_HALF_WINDOW)
                tmp_reg <= y_reg;
            else if (tmp_reg >= 10'(slots))
                tmp_reg <= tmp_reg - 10'(slots);
            else
                slot_reg <= SW'(tmp_reg);
        end
        else if (accept)
        begin
            if (WW'(x_reg) + WW'(1) >= width_reg)
            begin
                x_reg    <= '0;
                y_reg    <= y_inc;
                slot_reg <= (y_inc == '0) ? '0 : slot_inc;
            end
            else
            begin
                x_reg <= x_reg + XW'(1);
            end
        end
    end

    // window and disparity counters
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_x_reg      <= x_reg;
            job_y_reg      <= y_reg;
            start_slot_reg <= slot_inc;
            row_slot_reg   <= slot_inc;
            cnt_i_reg      <= '0;
            cnt_j_reg      <= '0;
            cnt_d_reg      <= '0;
        end
        else if (state_reg == ST_RUN)
        begin
            if (!end_i)
                cnt_i_reg <= cnt_i_reg + HW'(1);
            else
            begin
                cnt_i_reg <= '0;
                if (!end_j)
                begin
                    cnt_j_reg    <= cnt_j_reg + HW'(1);
                    row_slot_reg <= row_inc;
                end
                else
                begin
                    cnt_j_reg    <= '0;
                    row_slot_reg <= start_slot_reg;
                    cnt_d_reg    <= cnt_d_reg + DISP_W'(1);
                end
            end
        end
    end

    // read tag
    always_comb
    begin
        ctrl.valid   = (state_reg == ST_RUN);
        ctrl.first   = (cnt_i_reg == '0) && (cnt_j_reg == '0);
        ctrl.last    = end_i && end_j;
        ctrl.final_w = end_i && end_j && end_d;
        ctrl.zero_r  = (col < XW'(cnt_d_reg)) || (32'(cnt_d_reg) >= MAX_WIDTH);
        ctrl.disp    = cnt_d_reg;
    end

    sbmd_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_lines (
        .clk         (clk),
        .we          (accept),
        .waddr       (waddr),
        .wleft       (s_tdata[7:0]),
        .wright      (s_tdata[15:8]),
        .re          (state_reg == ST_RUN),
        .raddr_left  (raddr_l),
        .raddr_right (raddr_r),
        .rleft       (rd_left),
        .rright      (rd_right)
    );

    sbmd_ssd_engine #(
        .SUM_W (SUM_W)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .left_px   (rd_left),
        .right_px  (rd_right),
        .done      (eng_done),
        .best_disp (best_disp),
        .best_cost (best_cost)
    );

    // output register
    assign cx_full = XW'(job_x_reg - XW'(half_reg));
    assign cy_full = 10'(job_y_reg - 10'(half_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (load_out)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_data_reg <= {5'd0, COST_W'(best_cost), cy_full, COORD_W'(cx_full),
                           7'(best_disp)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

// ===== hdl/sbmd_checker.sv =====
// Port-level checks for the disparity block, bound to the top level.
`default_nettype none
module sbmd_checker
    import sbmd_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a new result follows a search, during which no pixel is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a search");

    // padding bits stay clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1:51] == '0)
        else $error("padding bits set in result beat");

endmodule

bind ssd_block_match_disparity sbmd_checker u_sbmd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
